[rtl/core/arp_rr_pkg.sv]
package arp_rr_pkg;

    localparam int PORT_COUNT = 8;
    localparam int REPLY_LEN  = 42;
    localparam int POS_W      = 6;

    // configuration register indexes
    localparam logic CFG_OWN_MAC = 1'b0;
    localparam logic CFG_OWN_IP  = 1'b1;

    // frame offsets of the arp payload fields
    localparam logic [POS_W-1:0] POS_SHA = 6'd22;  // sender mac
    localparam logic [POS_W-1:0] POS_SPA = 6'd28;  // sender ip
    localparam logic [POS_W-1:0] POS_THA = 6'd32;  // target mac
    localparam logic [POS_W-1:0] POS_TPA = 6'd38;  // target ip

    // ethertype, htype, ptype, hlen, plen, oper (reply) of the outgoing frame
    localparam logic [7:0] REPLY_FIXED [10] = '{
        8'h08, 8'h06, 8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h02
    };

    typedef struct packed {
        logic       check;
        logic [7:0] value;
    } t_hdr_exp;

    typedef struct packed {
        logic        fire;
        logic [47:0] peer_mac;
        logic [31:0] peer_ip;
        logic [2:0]  port;
    } t_reply_req;

    function automatic t_hdr_exp expected_byte(logic [POS_W-1:0] pos);
        t_hdr_exp e;
        e.check = 1'b1;
        case (pos)
            6'd12:   e.value = 8'h08;
            6'd13:   e.value = 8'h06;
            6'd14:   e.value = 8'h00;
            6'd15:   e.value = 8'h01;
            6'd16:   e.value = 8'h08;
            6'd17:   e.value = 8'h00;
            6'd20:   e.value = 8'h00;
            6'd21:   e.value = 8'h01;
            default: begin
                e.check = 1'b0;
                e.value = 8'h00;
            end
        endcase
        return e;
    endfunction

    function automatic logic [7:0] mac_byte(logic [47:0] mac, logic [2:0] i);
        return mac[8*(5-int'(i)) +: 8];
    endfunction

    function automatic logic [7:0] ip_byte(logic [31:0] ip, logic [1:0] i);
        return ip[8*(3-int'(i)) +: 8];
    endfunction

    function automatic logic [7:0] reply_at(logic [POS_W-1:0] i, logic [47:0] peer_mac,
                                            logic [31:0] peer_ip, logic [47:0] own_mac,
                                            logic [31:0] own_ip);
        logic [7:0] b;
        if (i < 6'd6)        b = mac_byte(peer_mac, 3'(i));
        else if (i < 6'd12)  b = mac_byte(own_mac, 3'(i - 6'd6));
        else if (i < POS_SHA) b = REPLY_FIXED[4'(i - 6'd12)];
        else if (i < POS_SPA) b = mac_byte(own_mac, 3'(i - POS_SHA));
        else if (i < POS_THA) b = ip_byte(own_ip, 2'(i - POS_SPA));
        else if (i < POS_TPA) b = mac_byte(peer_mac, 3'(i - POS_THA));
        else                  b = ip_byte(peer_ip, 2'(i - POS_TPA));
        return b;
    endfunction

endpackage

[rtl/core/arp_rr_cell.sv]
module arp_rr_cell import arp_rr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_load,
    input  logic       i_shift,
    input  logic [7:0] i_load_byte,
    input  logic [7:0] i_next_byte,
    output logic [7:0] o_byte
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_load) begin
            n_byte = i_load_byte;
        end else if (i_shift) begin
            n_byte = i_next_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;

endmodule

[rtl/core/arp_rr_parser.sv]
module arp_rr_parser import arp_rr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic [2:0]  i_port,
    input  logic [31:0] i_own_ip,
    output t_reply_req  o_req
);

    logic [POS_W-1:0] r_pos;
    logic             r_match;
    logic [47:0]      r_peer_mac;
    logic [31:0]      r_peer_ip;
    logic [2:0]       r_port;

    logic [POS_W-1:0] n_pos;
    logic             n_match;
    logic [47:0]      n_peer_mac;
    logic [31:0]      n_peer_ip;
    logic [2:0]       n_port;
    t_hdr_exp         exp_b;

    always_comb begin
        n_match    = r_match;
        n_port     = r_port;
        n_peer_mac = r_peer_mac;
        n_peer_ip  = r_peer_ip;
        n_pos      = r_pos;
        exp_b      = expected_byte(r_pos);
        if (r_pos == '0) begin
            n_port = i_port;
            if (int'(i_port) >= PORT_COUNT) n_match = 1'b0;
        end
        if (r_pos < POS_W'(REPLY_LEN)) begin
            if (exp_b.check && (i_byte != exp_b.value)) n_match = 1'b0;
            if (r_pos >= POS_SHA && r_pos < POS_SPA) begin
                n_peer_mac = {r_peer_mac[39:0], i_byte};
            end else if (r_pos >= POS_SPA && r_pos < POS_THA) begin
                n_peer_ip = {r_peer_ip[23:0], i_byte};
            end else if (r_pos >= POS_TPA &&
                         i_byte != ip_byte(i_own_ip, 2'(r_pos - POS_TPA))) begin
                n_match = 1'b0;
            end
            n_pos = r_pos + 6'd1;
        end
    end

    // a full-length request that passed every check triggers on its last byte
    always_comb begin
        o_req.fire     = i_accept && i_last && (n_pos == POS_W'(REPLY_LEN)) && n_match;
        o_req.peer_mac = n_peer_mac;
        o_req.peer_ip  = n_peer_ip;
        o_req.port     = n_port;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_match    <= 1'b1;
            r_peer_mac <= '0;
            r_peer_ip  <= '0;
            r_port     <= '0;
        end else if (i_accept) begin
            r_peer_mac <= n_peer_mac;
            r_peer_ip  <= n_peer_ip;
            r_port     <= n_port;
            if (i_last) begin
                r_pos   <= '0;
                r_match <= 1'b1;
            end else begin
                r_pos   <= n_pos;
                r_match <= n_match;
            end
        end
    end

endmodule

[rtl/core/arp_rr_chain.sv]
module arp_rr_chain import arp_rr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_reply_req  i_req,
    input  logic [47:0] i_own_mac,
    input  logic [31:0] i_own_ip,
    input  logic        i_ready,
    output logic        o_valid,
    output logic        o_last,
    output logic [7:0]  o_byte,
    output logic [2:0]  o_port,
    output logic        o_busy
);

    logic [POS_W-1:0] r_left;
    logic [POS_W-1:0] n_left;
    logic [2:0]       r_port;
    logic             shift;
    logic [7:0]       cell_byte [REPLY_LEN+1];

    assign shift   = o_valid && i_ready;
    assign cell_byte[REPLY_LEN] = 8'h00;

    for (genvar g = 0; g < REPLY_LEN; g++) begin : g_cell
        arp_rr_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (i_req.fire),
            .i_shift     (shift),
            .i_load_byte (reply_at(POS_W'(g), i_req.peer_mac, i_req.peer_ip,
                                   i_own_mac, i_own_ip)),
            .i_next_byte (cell_byte[g+1]),
            .o_byte      (cell_byte[g])
        );
    end

    always_comb begin
        n_left = r_left;
        if (i_req.fire) begin
            n_left = POS_W'(REPLY_LEN);
        end else if (shift) begin
            n_left = r_left - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.fire) r_port <= i_req.port;
    end

    assign o_valid = (r_left != '0);
    assign o_busy  = o_valid;
    assign o_last  = (r_left == 6'd1);
    assign o_byte  = cell_byte[0];
    assign o_port  = r_port;

    a_no_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.fire |-> r_left == '0)
        else $error("reply loaded while previous reply still draining");

    a_load_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.fire |=> r_left == POS_W'(REPLY_LEN))
        else $error("reply count not set after load");

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= POS_W'(REPLY_LEN))
        else $error("reply count out of range");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(r_left) && $stable(cell_byte[0]))
        else $error("reply moved while stalled");

endmodule

[rtl/core/arp_request_responder_top.sv]
// arp request responder
// - slave stream: received ethernet frame, one byte per request starting at the
//   destination mac; tlast on the frame's last byte, tuser carries the ingress port
// - config channel: index 0 writes own mac (48 bits), index 1 own ip (32 bits);
//   always ready, write only while no frame or reply is in flight
// - master stream: 42-byte arp reply per matching arp request, tlast on byte 42,
//   tuser = {bypass (always 1), egress port}
// - frames are parsed at one byte per cycle unless a frame end waits, as described below
// - the reply is loaded in parallel into a row of 42 byte cells on the edge that
//   takes the request's last byte; its first byte is valid the next cycle and the
//   row shifts one cell per accepted output byte
// - while a reply is still draining, the slave side keeps taking bytes; only a byte
//   with tlast waits (tready low) until the cell row is empty
// - a stalled master side freezes the cell row; nothing is dropped
// - reset restarts the parse state and clears the reply count and own mac/ip to zero
module arp_request_responder_top import arp_rr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] frame_byte
    input  logic        i_s_tlast,
    input  logic [2:0]  i_s_tuser,   // [2:0] ingress_port
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [47:0] i_cfg_data,
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] reply_byte
    output logic        o_m_tlast,
    output logic [3:0]  o_m_tuser    // [2:0] egress_port, [3] bypass_flag
);

    logic [47:0] r_own_mac;
    logic [31:0] r_own_ip;
    logic        in_accept;
    logic        busy;
    logic [2:0]  out_port;
    t_reply_req  req;

    // config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac <= '0;
            r_own_ip  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OWN_MAC: r_own_mac <= i_cfg_data;
                CFG_OWN_IP:  r_own_ip  <= i_cfg_data[31:0];
                default:     r_own_mac <= r_own_mac;
            endcase
        end
    end

    // only a frame end has to wait for the cell row to empty
    assign o_s_tready = !busy || !i_s_tlast;
    assign in_accept  = i_s_tvalid && o_s_tready;

    arp_rr_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .i_port   (i_s_tuser),
        .i_own_ip (r_own_ip),
        .o_req    (req)
    );

    arp_rr_chain u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .i_own_mac (r_own_mac),
        .i_own_ip  (r_own_ip),
        .i_ready   (i_m_tready),
        .o_valid   (o_m_tvalid),
        .o_last    (o_m_tlast),
        .o_byte    (o_m_tdata),
        .o_port    (out_port),
        .o_busy    (busy)
    );

    assign o_m_tuser = {1'b1, out_port};

endmodule

[tb/arp_checker.sv]
package arp_frame_pkg;

    // arp over ethernet header codes, as seen on the wire
    localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
    localparam logic [15:0] HTYPE_ETHERNET = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4     = 16'h0800;
    localparam logic [7:0]  HLEN_ETHERNET  = 8'd6;
    localparam logic [7:0]  PLEN_IPV4      = 8'd4;
    localparam logic [15:0] OPER_REQUEST   = 16'h0001;
    localparam logic [15:0] OPER_REPLY     = 16'h0002;

endpackage

module arp_checker import arp_rr_pkg::*; import arp_frame_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tlast,
    input  logic [2:0]  i_s_tuser,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [47:0] i_cfg_data,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,
    input  logic        i_m_tlast,
    input  logic [3:0]  i_m_tuser,
    output int          o_errors,
    output int          o_pending,
    output int          o_replies
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [2:0] port;
        logic       bypass;
    } t_reply_beat;

    // bytes 12..21 of an arp request; 18 and 19 (hlen, plen) are not checked
    localparam logic [79:0] REQ_HEADER = {ETHERTYPE_ARP, HTYPE_ETHERNET, PTYPE_IPV4,
                                          HLEN_ETHERNET, PLEN_IPV4, OPER_REQUEST};

    t_reply_beat pending_reply_bytes[$];

    logic [47:0] own_mac;
    logic [31:0] own_ip;
    logic [5:0]  rx_pos;
    logic        rx_match;
    logic [47:0] peer_mac;
    logic [31:0] peer_ip;
    logic [2:0]  rx_port;

    int err_count = 0;
    int reply_count = 0;
    int beat_idx = 0;

    assign o_errors  = err_count;
    assign o_replies = reply_count;

    task automatic parse_frame_byte(input logic [7:0] b, input logic last,
                                    input logic [2:0] port);
        logic [335:0] reply;
        int           p;
        p = rx_pos;
        if (p == 0) begin
            rx_port = port;
            if (int'(port) >= PORT_COUNT)
                rx_match = 1'b0;
        end
        if (p < REPLY_LEN) begin
            if (p >= 12 && p < 22 && p != 18 && p != 19 && b != REQ_HEADER[79 - 8*(p-12) -: 8])
                rx_match = 1'b0;
            if (p >= 22 && p < 28)
                peer_mac = {peer_mac[39:0], b};
            else if (p >= 28 && p < 32)
                peer_ip = {peer_ip[23:0], b};
            else if (p >= 38 && b != own_ip[31 - 8*(p-38) -: 8])
                rx_match = 1'b0;
            p++;
        end
        if (last) begin
            if (p >= REPLY_LEN && rx_match) begin
                reply = {peer_mac, own_mac, ETHERTYPE_ARP, HTYPE_ETHERNET, PTYPE_IPV4,
                         HLEN_ETHERNET, PLEN_IPV4, OPER_REPLY, own_mac, own_ip,
                         peer_mac, peer_ip};
                for (int i = 0; i < REPLY_LEN; i++)
                    pending_reply_bytes.push_back({reply[335 - 8*i -: 8], i == REPLY_LEN - 1,
                                                   rx_port, 1'b1});
                reply_count++;
            end
            rx_pos   = '0;
            rx_match = 1'b1;
        end else begin
            rx_pos = 6'(p);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_reply_beat got;
        t_reply_beat want;
        if (!i_rst_n) begin
            own_mac  = '0;
            own_ip   = '0;
            rx_pos   = '0;
            rx_match = 1'b1;
            peer_mac = '0;
            peer_ip  = '0;
            rx_port  = '0;
            pending_reply_bytes.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_OWN_MAC)
                    own_mac = i_cfg_data;
                else
                    own_ip = i_cfg_data[31:0];
            end
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tdata, i_m_tlast, i_m_tuser[2:0], i_m_tuser[3]};
                if (pending_reply_bytes.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: unexpected reply byte data %02h last %b port %0d bypass %b",
                                 $realtime, got.data, got.last, got.port, got.bypass);
                end else begin
                    want = pending_reply_bytes.pop_front();
                    if (got.data != want.data || got.last != want.last ||
                        got.port != want.port || got.bypass != want.bypass) begin
                        err_count++;
                        if (err_count <= 10)
                            $display({"%0t: reply byte %0d: expected data %02h last %b port %0d ",
                                      "bypass %b, got data %02h last %b port %0d bypass %b"},
                                     $realtime, beat_idx, want.data, want.last, want.port,
                                     want.bypass, got.data, got.last, got.port, got.bypass);
                    end
                end
                beat_idx = got.last ? 0 : beat_idx + 1;
            end
            if (i_s_tvalid && i_s_tready)
                parse_frame_byte(i_s_tdata, i_s_tlast, i_s_tuser);
            o_pending <= pending_reply_bytes.size();
        end
    end

endmodule

[tb/tb.sv]
module tb;
    import arp_rr_pkg::*;
    import arp_frame_pkg::*;

    // cycles with no request on any channel before the run is declared hung;
    // worst honest case is a long receiver stall or sender gap
    localparam int STALL_LIMIT   = 2000;
    // quiet cycles after the last reply byte before touching the registers
    localparam int SETTLE_CYCLES = 8;
    // random frame bytes under the random register setting
    localparam int PHASE_BYTES   = 48;
    localparam int MAX_FRAME_LEN = 48;

    typedef enum int {
        FR_REQUEST,
        FR_BAD_FIELD,
        FR_OTHER_OPER,
        FR_SHORT,
        FR_NOISE
    } t_frame_kind;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_MASKED,
        RX_RANDOM
    } t_rx_mode;

    // one received frame, header fields in wire order plus length and port
    typedef struct {
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [15:0] ethertype;
        logic [15:0] htype;
        logic [15:0] ptype;
        logic [7:0]  hlen;
        logic [7:0]  plen;
        logic [15:0] oper;
        logic [47:0] sha;
        logic [31:0] spa;
        logic [47:0] tha;
        logic [31:0] tpa;
        int          len;
        logic [2:0]  port;
    } t_arp_frame;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic [2:0]  s_tuser   = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_OWN_MAC;
    logic [47:0] cfg_data  = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [3:0]  m_tuser;

    int errors;
    int pending;
    int replies;

    // sender burst state
    int burst_left = 0;
    int gap_max    = 0;

    // run bookkeeping for the summary
    int frames_sent = 0;
    int bytes_sent  = 0;
    int settings    = 1;

    // current register contents, so requests can target this station
    logic [47:0] station_mac = '0;
    logic [31:0] station_ip  = '0;

    // receiver stall pattern
    t_rx_mode    rx_mode = RX_OPEN;
    logic [15:0] rx_mask = '1;
    logic [6:0]  rx_tick = '0;

    int idle_cycles = 0;

    arp_request_responder_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .i_s_tuser   (s_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .o_m_tuser   (m_tuser)
    );

    arp_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .i_s_tuser   (s_tuser),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tlast   (m_tlast),
        .i_m_tuser   (m_tuser),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_replies   (replies)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: at each wrap of the tick counter pick fully open, a rotating 16-bit mask
    // (bit 0 forced so no stall outlasts one pass through the mask) or random ready
    always @(posedge clk) begin
        rx_tick <= rx_tick + 7'd1;
        if (rx_tick == '0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 2));
            rx_mask <= 16'($urandom) | 16'h0001;
        end
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_MASKED: m_tready <= rx_mask[rx_tick[3:0]];
            default:   m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // watchdog: any request on any channel counts as progress
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no request for %0d cycles, %0d reply bytes outstanding",
                         idle_cycles, pending);
                $display("[arp_request_responder_top] ERROR");
                $finish;
            end
        end
    end

    // one frame byte; a burst that ran out is followed by a random gap
    task automatic send_byte(input logic [7:0] b, input logic last, input logic [2:0] port);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        s_tuser  <= port;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        burst_left--;
    endtask

    // sender holds off until every predicted reply byte has been taken;
    // the first edge lets the checker's count catch up with the last request
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // both registers back to back; the ip write carries junk in the unused upper bits
    task automatic program_station(input logic [47:0] mac, input logic [31:0] ip);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_OWN_MAC;
        cfg_data  <= mac;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= CFG_OWN_IP;
        cfg_data  <= {16'($urandom), ip};
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid   <= 1'b0;
        station_mac = mac;
        station_ip  = ip;
        settings++;
    endtask

    // well-formed request for this station, random content
    function automatic t_arp_frame make_request();
        t_arp_frame f;
        f.dst_mac   = ($urandom_range(0, 1) != 0) ? '1 : 48'({$urandom, $urandom});
        f.src_mac   = 48'({$urandom, $urandom});
        f.ethertype = ETHERTYPE_ARP;
        f.htype     = HTYPE_ETHERNET;
        f.ptype     = PTYPE_IPV4;
        f.hlen      = HLEN_ETHERNET;
        f.plen      = PLEN_IPV4;
        // the length bytes are don't-care
        if ($urandom_range(0, 3) == 0) begin
            f.hlen = 8'($urandom);
            f.plen = 8'($urandom);
        end
        f.oper = OPER_REQUEST;
        f.sha  = ($urandom_range(0, 4) == 0) ? 48'({$urandom, $urandom}) : f.src_mac;
        f.spa  = $urandom;
        f.tha  = ($urandom_range(0, 1) != 0) ? '0 : 48'({$urandom, $urandom});
        f.tpa  = station_ip;
        f.len  = ($urandom_range(0, 2) == 0) ? REPLY_LEN :
                 $urandom_range(REPLY_LEN + 1, MAX_FRAME_LEN);
        f.port = 3'($urandom);
        return f;
    endfunction

    // mostly good requests, the rest broken or foreign frames
    function automatic t_arp_frame random_frame();
        t_arp_frame  f;
        t_frame_kind kind;
        int          r;
        r = $urandom_range(0, 9);
        kind = (r < 6) ? FR_REQUEST : (r == 6) ? FR_BAD_FIELD : (r == 7) ? FR_OTHER_OPER :
               (r == 8) ? FR_SHORT : FR_NOISE;
        f = make_request();
        case (kind)
            FR_BAD_FIELD: begin
                case ($urandom_range(0, 4))
                    0:       f.ethertype ^= 16'h1 << $urandom_range(0, 15);
                    1:       f.htype ^= 16'h1 << $urandom_range(0, 15);
                    2:       f.ptype ^= 16'h1 << $urandom_range(0, 15);
                    3:       f.oper ^= 16'h1 << $urandom_range(0, 15);
                    default: f.tpa ^= 32'h1 << $urandom_range(0, 31);
                endcase
            end
            FR_OTHER_OPER: f.oper = ($urandom_range(0, 1) != 0) ? OPER_REPLY : 16'($urandom);
            FR_SHORT:      f.len = $urandom_range(1, REPLY_LEN - 1);
            FR_NOISE: begin
                f.dst_mac   = 48'({$urandom, $urandom});
                f.src_mac   = 48'({$urandom, $urandom});
                f.ethertype = 16'($urandom);
                f.htype     = 16'($urandom);
                f.ptype     = 16'($urandom);
                f.hlen      = 8'($urandom);
                f.plen      = 8'($urandom);
                f.oper      = 16'($urandom);
                f.sha       = 48'({$urandom, $urandom});
                f.spa       = $urandom;
                f.tha       = 48'({$urandom, $urandom});
                f.tpa       = $urandom;
                f.len       = $urandom_range(1, MAX_FRAME_LEN);
            end
            default: ;
        endcase
        return f;
    endfunction

    // serialize header, then random padding; tuser only matters on the first byte
    task automatic send_frame(input t_arp_frame f);
        logic [335:0] hdr;
        logic [7:0]   b;
        hdr = {f.dst_mac, f.src_mac, f.ethertype, f.htype, f.ptype, f.hlen, f.plen, f.oper,
               f.sha, f.spa, f.tha, f.tpa};
        // some frames go back to back, others with gaps of varying size
        gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        for (int i = 0; i < f.len; i++) begin
            b = (i < REPLY_LEN) ? hdr[335 - 8*i -: 8] : 8'($urandom);
            send_byte(b, i == f.len - 1, (i == 0) ? f.port : 3'($urandom));
        end
        frames_sent++;
        bytes_sent += f.len;
    endtask

    initial begin
        t_arp_frame f;
        int         phase_start;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers are zero out of reset: an all-zero request to ip 0 is answered
        f = make_request();
        f.dst_mac = '0;
        f.src_mac = '0;
        f.sha     = '0;
        f.spa     = '0;
        f.tha     = '0;
        f.len     = REPLY_LEN;
        f.port    = '0;
        send_frame(f);
        wait_drained();

        // all-ones station and all-ones request on the highest port, padded with
        // odd length bytes: bytes past 42 ignored, still answered
        program_station('1, '1);
        f = make_request();
        f.dst_mac = '1;
        f.src_mac = '1;
        f.sha     = '1;
        f.spa     = '1;
        f.tha     = '1;
        f.len     = MAX_FRAME_LEN;
        f.port    = '1;
        f.hlen    = '1;
        f.plen    = '0;
        send_frame(f);

        // arp reply: ignored
        f = make_request();
        f.oper = OPER_REPLY;
        f.len  = REPLY_LEN;
        send_frame(f);

        // one byte short of a full arp frame: no reply
        f = make_request();
        f.len = REPLY_LEN - 1;
        send_frame(f);

        // single-byte frame, tlast on the first byte
        f = make_request();
        f.len = 1;
        send_frame(f);
        wait_drained();

        // random traffic under a random setting
        program_station(48'({$urandom, $urandom}), $urandom);
        phase_start = bytes_sent;
        while (bytes_sent - phase_start < PHASE_BYTES) begin
            send_frame(random_frame());
            // now and then let everything drain before the next frame
            if ($urandom_range(0, 3) == 0)
                wait_drained();
        end
        wait_drained();

        $display("run: %0d frames, %0d bytes under %0d station settings (good, short, padded,",
                 frames_sent, bytes_sent, settings);
        $display("     bad-header, non-request, noise); %0d replies predicted, %0d mismatches",
                 replies, errors);
        if (errors == 0 && pending == 0)
            $display("[arp_request_responder_top] OK");
        else
            $display("[arp_request_responder_top] ERROR");
        $finish;
    end

endmodule
